// ----- rtl/pcl_pkg.sv -----
// ----------------------------------------------------------------------------
// pcl_pkg
// shared types and codes for the positional circular list core
// ----------------------------------------------------------------------------
package pcl_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int CMD_W       = 3;
  localparam int POS_W       = 5;
  localparam int DATA_W      = 32;
  localparam int LEN_W       = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FIRST = 3'd0,
    CMD_INS_LAST  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_LAST  = 3'd4,
    CMD_DEL_AT    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } status_t;

  // what every cell of the row is told to do
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_EMIT,
    S_ONE
  } state_t;

endpackage

// ----- rtl/pcl_cell.sv -----
// ----------------------------------------------------------------------------
// pcl_cell
// one list position: holds a value, takes it from a neighbor on shifts
// ----------------------------------------------------------------------------
module pcl_cell
  import pcl_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IDX_W = 4,
  parameter int W     = 32
) (
  input  logic                clk,
  input  cell_op_t            op,
  input  logic [IDX_W-1:0]    sel_idx,
  input  logic [IDX_W-1:0]    last_idx,
  input  logic signed [W-1:0] new_val,
  input  logic signed [W-1:0] left_val,
  input  logic signed [W-1:0] right_val,
  input  logic signed [W-1:0] wrap_val,
  output logic signed [W-1:0] val
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (op)
      CELL_INS: begin
        if (MY_IDX > sel_idx) begin
          val_next = left_val;
        end else if (MY_IDX == sel_idx) begin
          val_next = new_val;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= sel_idx && MY_IDX < last_idx) begin
          val_next = right_val;
        end
      end
      CELL_ROT: begin
        // head leaves at cell 0 and wraps back in at the tail
        if (MY_IDX < last_idx) begin
          val_next = right_val;
        end else if (MY_IDX == last_idx) begin
          val_next = wrap_val;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ----- rtl/positional_circular_list_core.sv -----
// ----------------------------------------------------------------------------
// positional_circular_list_core
// ordered list of signed values kept in a row of cells; insert and delete by
// position, then stream the whole list out from head to tail
// ----------------------------------------------------------------------------
// a good command passes through S_OP, where the cell row is updated, and
// then S_EMIT, which loads a result into the output register whenever it
// is free, with one rotation step of the cell row per result; a failed
// command (or deleting the only entry) goes to S_ONE for a single item
// one command is in flight at a time; results wait in an output register
// reset (synchronous): list empty, output idle; cell contents are left as is
// ----------------------------------------------------------------------------
module positional_circular_list_core
  import pcl_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // command [2:0], position [7:3], value [39:8]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status [1:0], element [33:2], element_position [38:34], list_empty [39],
  // list_length [44:40], zero fill [47:45]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  state_t              state, state_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    emit_n;
  cell_op_t            op_mode;
  logic [IDX_W-1:0]    op_idx;
  logic signed [VALUE_BITS-1:0] ins_val;
  status_t             one_status;

  logic                out_valid;
  status_t             out_status;
  logic signed [DATA_W-1:0] out_elem;
  logic [POS_W-1:0]    out_epos;
  logic                out_empty;
  logic [LEN_W-1:0]    out_len;
  logic                out_last;

  // input fields
  logic [CMD_W-1:0]          in_cmd;
  logic [POS_W-1:0]          in_pos;
  logic signed [DATA_W-1:0]  in_value;
  logic signed [VALUE_BITS-1:0] in_fit;
  logic [CMP_W-1:0]          pos_w, cnt_w;

  assign in_cmd   = s_axis_tdata[CMD_W-1:0];
  assign in_pos   = s_axis_tdata[CMD_W+POS_W-1:CMD_W];
  assign in_value = s_axis_tdata[CMD_W+POS_W+DATA_W-1:CMD_W+POS_W];
  assign in_fit   = VALUE_BITS'(in_value);
  assign pos_w    = CMP_W'(in_pos);
  assign cnt_w    = CMP_W'(count);

  logic     accept;
  logic     dec_known, dec_fail;
  status_t  dec_status;
  cell_op_t dec_mode;
  logic [IDX_W-1:0] dec_idx;
  logic     is_full, is_empty;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_full       = (cnt_w >= CMP_W'(CAPACITY));
  assign is_empty      = (count == '0);

  always_comb begin
    dec_known  = 1'b1;
    dec_fail   = 1'b0;
    dec_status = ST_OK;
    dec_mode   = CELL_INS;
    dec_idx    = '0;
    case (cmd_t'(in_cmd))
      CMD_INS_FIRST: begin
        if (is_full) begin
          dec_fail   = 1'b1;
          dec_status = ST_OVER;
        end
      end
      CMD_INS_LAST: begin
        dec_idx = IDX_W'(count);
        if (is_full) begin
          dec_fail   = 1'b1;
          dec_status = ST_OVER;
        end
      end
      CMD_INS_AT: begin
        dec_idx = IDX_W'(pos_w - CMP_W'(1));
        if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
          dec_fail   = 1'b1;
          dec_status = ST_BADPOS;
        end else if (is_full) begin
          dec_fail   = 1'b1;
          dec_status = ST_OVER;
        end
      end
      CMD_DEL_FIRST: begin
        dec_mode = CELL_DEL;
        if (is_empty) begin
          dec_fail   = 1'b1;
          dec_status = ST_UNDER;
        end
      end
      CMD_DEL_LAST: begin
        dec_mode = CELL_DEL;
        dec_idx  = IDX_W'(cnt_w - CMP_W'(1));
        if (is_empty) begin
          dec_fail   = 1'b1;
          dec_status = ST_UNDER;
        end
      end
      CMD_DEL_AT: begin
        dec_mode = CELL_DEL;
        dec_idx  = IDX_W'(pos_w - CMP_W'(1));
        if (is_empty) begin
          dec_fail   = 1'b1;
          dec_status = ST_UNDER;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          dec_fail   = 1'b1;
          dec_status = ST_BADPOS;
        end
      end
      default: dec_known = 1'b0;
    endcase
  end

  // output register handshake
  logic out_free, out_load, emit_last;

  assign out_free  = !out_valid || m_axis_tready;
  assign out_load  = out_free && (state == S_EMIT || state == S_ONE);
  assign emit_last = (emit_n + CNT_W'(1) == count);

  // cell row
  logic signed [VALUE_BITS-1:0] cell_val [CAPACITY];
  cell_op_t         cell_op;
  logic [IDX_W-1:0] last_idx;

  assign last_idx = IDX_W'(count - CNT_W'(1));

  always_comb begin
    case (state)
      S_OP:    cell_op = op_mode;
      S_EMIT:  cell_op = out_free ? CELL_ROT : CELL_HOLD;
      default: cell_op = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] left_v, right_v;
    if (i == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end
    pcl_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .W     (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .sel_idx   (op_idx),
      .last_idx  (last_idx),
      .new_val   (ins_val),
      .left_val  (left_v),
      .right_val (right_v),
      .wrap_val  (cell_val[0]),
      .val       (cell_val[i])
    );
  end

  // control state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && dec_known) begin
          state_next = dec_fail ? S_ONE : S_OP;
        end
      end
      S_OP: begin
        // deleting the only entry leaves a single empty-list item
        if (op_mode == CELL_DEL && count == CNT_W'(1)) begin
          state_next = S_ONE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && emit_last) begin
          state_next = S_IDLE;
        end
      end
      S_ONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OP) begin
        count <= (op_mode == CELL_INS) ? count + CNT_W'(1) : count - CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode    <= dec_mode;
      op_idx     <= dec_idx;
      ins_val    <= in_fit;
      one_status <= dec_status;
    end
    if (state == S_OP) begin
      emit_n <= '0;
    end else if (state == S_EMIT && out_free) begin
      emit_n <= emit_n + CNT_W'(1);
    end
    if (out_load) begin
      out_len   <= LEN_W'(count);
      out_empty <= (count == '0);
      if (state == S_EMIT) begin
        out_status <= ST_OK;
        out_elem   <= DATA_W'(cell_val[0]);
        out_epos   <= POS_W'(emit_n + CNT_W'(1));
        out_last   <= emit_last;
      end else begin
        out_status <= one_status;
        out_elem   <= '0;
        out_epos   <= '0;
        out_last   <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {3'b000, out_len, out_empty, out_epos, out_elem, out_status};

endmodule

// ----- rtl/pcl_checker.sv -----
// ----------------------------------------------------------------------------
// pcl_checker
// port-level checks for the positional circular list core
// ----------------------------------------------------------------------------
module pcl_checker
  import pcl_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // an error item is alone and carries no element
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |->
      m_axis_tlast && m_axis_tdata[38:2] == '0)
    else $error("error item not a lone empty item");

  // items inside a run are good list entries
  a_run_body: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |->
      m_axis_tdata[1:0] == ST_OK && !m_axis_tdata[39] && m_axis_tdata[38:34] != '0)
    else $error("bad item inside a run");

  // a known command blocks the input: ready is low right after it is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] <= CMD_DEL_AT |=>
      !s_axis_tready)
    else $error("input ready right after a command");

endmodule

bind positional_circular_list_core pcl_checker u_pcl_checker (.*);
